// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg - text console character writer shared definitions
// Screen geometry, op and character codes, controller/datapath command and
// status structs, and the tab stop helper.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  // fixed field widths of the channels
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int COLR_W = 4;
  localparam int IDX_W  = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;

  // enough tab stops to pass the last column
  localparam int TAB_COUNT = COLUMNS / TAB_STOP + 1;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  typedef struct packed {
    logic latch;
    logic exec;
    logic fill_step;
    logic scroll_step;
    logic rd_issue;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic op_put;
    logic op_clear;
    logic need_scroll;
    logic fill_last;
    logic row_last;
    logic out_free;
  } tcw_status_t;

  // next multiple of the tab stop above col
  function automatic logic [COL_W:0] tab_next(input logic [COL_W-1:0] col);
    logic [COL_W:0] res;
    res = '0;
    for (int i = TAB_COUNT; i >= 1; i--) begin
      if ({1'b0, col} < (COL_W+1)'(i * TAB_STOP)) begin
        res = (COL_W+1)'(i * TAB_STOP);
      end
    end
    return res;
  endfunction

endpackage

// ===== design/tcw_if.sv =====
// ----------------------------------------------------------------------------
// tcw_if - channel interfaces of the text console character writer
// Valid/ready channels for put/clear/read requests and for results.
// ----------------------------------------------------------------------------
interface tcw_in_if
  import tcw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] char_code;
  logic [COLR_W-1:0] bg_colour;
  logic [COLR_W-1:0] fg_colour;
  logic [IDX_W-1:0]  cell_index;

  modport source (
    output valid, op, char_code, bg_colour, fg_colour, cell_index,
    input  ready
  );
  modport sink (
    input  valid, op, char_code, bg_colour, fg_colour, cell_index,
    output ready
  );
endinterface

interface tcw_out_if
  import tcw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [LOC_W-1:0]  cursor_addr;
  logic [CELL_W-1:0] cell_value;

  modport source (
    output valid, cursor_row, cursor_col, cursor_addr, cell_value,
    input  ready
  );
  modport sink (
    input  valid, cursor_row, cursor_col, cursor_addr, cell_value,
    output ready
  );
endinterface

// ===== design/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram - generic simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl - text console controller
// Sequences reset fill, cursor update, clear fill, row scroll, cell read
// and result capture.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tcw_status_t status,
  output tcw_cmd_t    cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_CAP    = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.op_clear) begin
          state_nxt = S_FILL;
        end else if (status.op_put && status.need_scroll) begin
          state_nxt = S_SCROLL;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) state_nxt = S_RD;
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (status.row_last) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CAP;
      end
      S_CAP: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath - text console datapath
// Cursor registers, scroll base of the row ring, sweep counter, store port
// steering and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_cmd_t           cmd,
  output tcw_status_t        status,
  input  logic [OP_W-1:0]    in_op,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic [COLR_W-1:0]  in_bg_colour,
  input  logic [COLR_W-1:0]  in_fg_colour,
  input  logic [IDX_W-1:0]   in_cell_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROW_W-1:0]   out_cursor_row,
  output logic [COL_W-1:0]   out_cursor_col,
  output logic [LOC_W-1:0]   out_cursor_addr,
  output logic [CELL_W-1:0]  out_cell_value,
  output logic               ram_we,
  output logic [ADDR_W-1:0]  ram_waddr,
  output logic [CELL_W-1:0]  ram_wdata,
  output logic               ram_re,
  output logic [ADDR_W-1:0]  ram_raddr,
  input  logic [CELL_W-1:0]  ram_rdata
);

  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

  // store offset by the ring base, back into range with one subtract
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W+1)'(CELLS)) begin
      s = s - (ADDR_W+1)'(CELLS);
    end
    return s[ADDR_W-1:0];
  endfunction

  logic [OP_W-1:0]     op_r;
  logic [CHAR_W-1:0]   ch_r;
  logic [2*COLR_W-1:0] attr_r;
  logic [IDX_W-1:0]    idx_r;
  logic                idx_ok_r;
  logic [ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic                out_valid_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [COL_W-1:0]    out_col_r;
  logic [LOC_W-1:0]    out_loc_r;
  logic [CELL_W-1:0]   out_cell_r;

  logic [ADDR_W-1:0] cur_loc;
  logic [COL_W:0]    col_t;
  logic [ROW_W:0]    row_t;
  logic              wr_char;
  logic              need_scroll;
  logic              op_put;
  logic              op_clear;
  logic              fill_last;
  logic              row_last;
  logic              out_free;

  assign cur_loc  = ADDR_W'(cur_row_r) * COLS_A + ADDR_W'(cur_col_r);
  assign op_put   = (op_r == OP_PUT);
  assign op_clear = (op_r == OP_CLEAR);

  // cursor movement for one put
  always_comb begin
    col_t   = {1'b0, cur_col_r};
    row_t   = {1'b0, cur_row_r};
    wr_char = 1'b0;
    case (ch_r)
      CH_BS: begin
        if (cur_col_r != '0) col_t = col_t - 1'b1;
      end
      CH_TAB: begin
        col_t = tab_next(cur_col_r);
      end
      CH_CR: begin
        col_t = '0;
      end
      CH_LF: begin
        col_t = '0;
        row_t = row_t + 1'b1;
      end
      default: begin
        if (ch_r >= CH_PRINT_LO && ch_r <= CH_PRINT_HI) begin
          wr_char = 1'b1;
          col_t   = col_t + 1'b1;
        end
      end
    endcase
    if (col_t >= (COL_W+1)'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
  end

  assign need_scroll = (row_t >= (ROW_W+1)'(ROWS));
  assign fill_last   = (cnt_r == ADDR_W'(CELLS - 1));
  assign row_last    = (cnt_r == ADDR_W'(COLUMNS - 1));
  assign out_free    = !out_valid_r || out_ready;

  assign status.op_put      = op_put;
  assign status.op_clear    = op_clear;
  assign status.need_scroll = need_scroll;
  assign status.fill_last   = fill_last;
  assign status.row_last    = row_last;
  assign status.out_free    = out_free;

  // write port: sweeps first, then the character store
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = BLANK_CELL;
    if (cmd.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r;
    end else if (cmd.scroll_step) begin
      // the old top row becomes the new bottom row
      ram_we    = 1'b1;
      ram_waddr = base_r + cnt_r;
    end else if (cmd.exec && op_put && wr_char) begin
      ram_we    = 1'b1;
      ram_waddr = wrap_add(cur_loc, base_r);
      ram_wdata = {attr_r, ch_r};
    end
  end

  assign ram_re    = cmd.rd_issue;
  assign ram_raddr = wrap_add(ADDR_W'(idx_r), base_r);

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    base_nxt    = base_r;
    cnt_nxt     = cnt_r;
    if (cmd.exec) begin
      cnt_nxt = '0;
      if (op_clear) begin
        cur_row_nxt = '0;
        cur_col_nxt = '0;
        base_nxt    = '0;
      end else if (op_put) begin
        cur_col_nxt = col_t[COL_W-1:0];
        cur_row_nxt = need_scroll ? ROW_W'(ROWS - 1) : row_t[ROW_W-1:0];
      end
    end else if (cmd.fill_step) begin
      cnt_nxt = fill_last ? '0 : cnt_r + 1'b1;
    end else if (cmd.scroll_step) begin
      cnt_nxt = row_last ? '0 : cnt_r + 1'b1;
      if (row_last) base_nxt = wrap_add(base_r, COLS_A);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      base_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      base_r    <= base_nxt;
      cnt_r     <= cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_op;
      ch_r     <= in_char_code;
      attr_r   <= {in_bg_colour, in_fg_colour};
      idx_r    <= in_cell_index;
      idx_ok_r <= (int'(in_cell_index) < CELLS);
    end
    if (cmd.out_load) begin
      out_row_r  <= cur_row_r;
      out_col_r  <= cur_col_r;
      out_loc_r  <= LOC_W'(cur_loc);
      out_cell_r <= idx_ok_r ? ram_rdata : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_row  = out_row_r;
  assign out_cursor_col  = out_col_r;
  assign out_cursor_addr = out_loc_r;
  assign out_cell_value  = out_cell_r;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS))
    else $error("cursor outside the screen");

  a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(base_r) < CELLS)
    else $error("scroll base outside the store");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result overwritten before its transaction");

  a_sweep_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_step |-> !(cmd.scroll_step || cmd.exec || cmd.rd_issue))
    else $error("store sweep overlaps another store access");

endmodule

// ===== design/text_console_char_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer_top - text console character writer
// Put, clear and read requests against an 80x25 store of 16-bit cells.
// ----------------------------------------------------------------------------
// After reset the block blank-fills the whole store, one cell a cycle, and
// takes no request until that is done. A put or read then runs from its
// transaction to its result through accept, cursor update and character
// write, store read and result capture, all through the single write and
// single read port of the cell store. A put that runs off the last row
// also blanks the new bottom row, one cell a cycle; rows are kept as a
// ring, so nothing is copied. A clear blank-fills the whole store, one cell
// a cycle. A result waiting at the output holds the capture step until its
// transaction completes, and no new request is taken until then.
module text_console_char_writer_top
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  tcw_in_if.sink   in_ch,
  tcw_out_if.source out_ch
);

  tcw_cmd_t          cmd;
  tcw_status_t       status;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_op           (in_ch.op),
    .in_char_code    (in_ch.char_code),
    .in_bg_colour    (in_ch.bg_colour),
    .in_fg_colour    (in_ch.fg_colour),
    .in_cell_index   (in_ch.cell_index),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cursor_row  (out_ch.cursor_row),
    .out_cursor_col  (out_ch.cursor_col),
    .out_cursor_addr (out_ch.cursor_addr),
    .out_cell_value  (out_ch.cell_value),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
